@@ hdl/nmatb_pkg.sv @@
// Shared types, codes and constants of the alarm timer bank.
package nmatb_pkg;

    localparam int NUM_TIMERS  = 4;
    localparam int COUNT_WIDTH = 12;
    localparam int SEL_WIDTH   = $clog2(NUM_TIMERS);
    localparam int OP_WIDTH    = 3;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = SEL_WIDTH + 2;

    // operation codes; the remaining codes behave as a query
    localparam logic [OP_WIDTH-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_START  = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_QUERY  = 3'd4;

    // register indexes
    localparam logic [SEL_WIDTH-1:0] REG_TYPICAL_PERIOD = 2'd0;
    localparam logic [SEL_WIDTH-1:0] REG_MAX_PERIOD     = 2'd1;
    localparam logic [SEL_WIDTH-1:0] REG_ERROR_PERIOD   = 2'd2;
    localparam logic [SEL_WIDTH-1:0] REG_SLEEP_PERIOD   = 2'd3;

    localparam logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] PERIOD_RESET = {
        12'd500, 12'd100, 12'd26, 12'd10
    };

    typedef struct packed {
        logic                  valid;
        logic [OP_WIDTH-1:0]   op;
        logic [SEL_WIDTH-1:0]  sel;
    } t_cmd;

    typedef struct packed {
        logic                   en;
        logic [SEL_WIDTH-1:0]   idx;
        logic [COUNT_WIDTH-1:0] value;
    } t_cfg_wr;

    // packed so that the lowest bit is the selected flag
    typedef struct packed {
        logic [NUM_TIMERS-1:0] running_mask;
        logic [NUM_TIMERS-1:0] expired_mask;
        logic                  selected_timed_out;
    } t_result;

    localparam int RES_WIDTH  = $bits(t_result);
    localparam int OUT_TDATA_W = ((RES_WIDTH + 7) / 8) * 8;
    localparam int IN_TDATA_W  = ((OP_WIDTH + SEL_WIDTH + 7) / 8) * 8;

endpackage

@@ hdl/nmatb_timer_bank.sv @@
// Timer state, period registers and the per-operation update of the bank.
module nmatb_timer_bank
    import nmatb_pkg::*;
(
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_cmd                                   i_cmd,
    input  t_cfg_wr                                i_cfg,
    output t_result                                o_res,
    output logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] o_periods
);

    logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] r_period;
    logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] r_count, n_count;
    logic [NUM_TIMERS-1:0]                  r_running, n_running;
    logic [NUM_TIMERS-1:0]                  r_flag, n_flag;
    logic [COUNT_WIDTH-1:0]                 inc;

    always_comb begin
        n_count   = r_count;
        n_running = r_running;
        n_flag    = r_flag;
        inc       = '0;
        if (i_cmd.valid) begin
            case (i_cmd.op)
                OP_TICK: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        inc = r_count[i] + 1'b1;
                        if (!r_running[i]) begin
                            n_count[i] = '0;
                        end else if (inc >= r_period[i] || inc == '0) begin
                            n_count[i]   = '0;
                            n_flag[i]    = 1'b1;
                            n_running[i] = 1'b0;
                        end else begin
                            n_count[i] = inc;
                        end
                    end
                end
                OP_START: begin
                    n_running[i_cmd.sel] = 1'b1;
                    n_count[i_cmd.sel]   = '0;
                    n_flag[i_cmd.sel]    = 1'b0;
                end
                OP_CANCEL: begin
                    n_running[i_cmd.sel] = 1'b0;
                    n_count[i_cmd.sel]   = '0;
                    n_flag[i_cmd.sel]    = 1'b0;
                end
                OP_CLEAR: begin
                    n_flag[i_cmd.sel] = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_running <= '0;
            r_flag    <= '0;
            r_period  <= PERIOD_RESET;
        end else begin
            r_count   <= n_count;
            r_running <= n_running;
            r_flag    <= n_flag;
            if (i_cfg.en) begin
                r_period[i_cfg.idx] <= i_cfg.value;
            end
        end
    end

    // result reflects the state after this operation
    assign o_res.running_mask       = n_running;
    assign o_res.expired_mask       = n_flag;
    assign o_res.selected_timed_out = n_flag[i_cmd.sel];
    assign o_periods                = r_period;

endmodule

@@ hdl/network_mgmt_alarm_timer_bank_core.sv @@
// Top level of the one-shot alarm timer bank: stream ports, APB registers, result buffer.
//
// Four one-shot alarm timers (typical, maximum, error, wait-bus-sleep). Each
// word on the slave stream is one operation: tick (every running timer counts
// one; a timer whose count reaches its period drops to zero, sets its timeout
// flag and stops), start, cancel, clear flag or query on the selected timer.
// Every word yields exactly one result word with the selected timer's flag and
// the expired and running masks as they stand after the operation. The update
// is a single pass of compare and increment logic on the timer registers, so
// an operation is accepted in every cycle while s_tready is high; its result
// is registered into a two-word result buffer (output register plus skid
// register) that decouples the sides: s_tready falls only when both are
// full. Periods sit at APB byte addresses 0, 4, 8 and 12 (12 bits, reset
// 10, 26, 100, 500); write them only while the bank is idle.
module network_mgmt_alarm_timer_bank_core
    import nmatb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] operation, [4:3] timer_select
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] selected_timed_out, [4:1] expired_mask,
                                              // [8:5] running_mask
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_cmd    cmd;
    t_cfg_wr cfg;
    t_result bank_res;
    logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] periods;

    logic    accept;
    logic    pop;
    logic    r_out_valid;
    t_result r_out_data;
    logic    r_skid_valid;
    t_result r_skid_data;

    // ready as long as the skid register is free
    assign s_tready = !r_skid_valid;
    assign accept   = s_tvalid && s_tready;
    assign pop      = r_out_valid && m_tready;

    assign cmd.valid = accept;
    assign cmd.op    = s_tdata[OP_WIDTH-1:0];
    assign cmd.sel   = s_tdata[OP_WIDTH+SEL_WIDTH-1:OP_WIDTH];

    // APB: always ready, write at the access phase
    assign pready    = 1'b1;
    assign cfg.en    = psel && penable && pwrite;
    assign cfg.idx   = paddr[APB_AW-1:2];
    assign cfg.value = pwdata[COUNT_WIDTH-1:0];
    assign prdata    = {{(APB_DW-COUNT_WIDTH){1'b0}}, periods[paddr[APB_AW-1:2]]};

    nmatb_timer_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (cfg),
        .o_res     (bank_res),
        .o_periods (periods)
    );

    // result buffer: head register feeds the master stream, skid catches a
    // word accepted while the head is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            r_out_data <= r_skid_valid ? r_skid_data : bank_res;
        end else if (accept) begin
            r_skid_data <= bank_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_TDATA_W-RES_WIDTH){1'b0}}, r_out_data};

    // a full skid implies a word waiting at the head
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without a head word");

    // a timer never runs with its timeout flag set
    a_run_flag_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ((bank_res.running_mask & bank_res.expired_mask) == '0))
        else $error("timer running with timeout flag set");

    // a start leaves the selected timer running with its flag clear
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd.op == OP_START) |->
            (bank_res.running_mask[cmd.sel] && !bank_res.selected_timed_out))
        else $error("start did not arm the selected timer");

endmodule

@@ tb/sv/alarm_bank_checker.sv @@
// Scoreboard for the alarm timer bank: mirrors the four timers and checks each result word.
`timescale 1ns / 100ps

module alarm_bank_checker
    import nmatb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [2:0] operation, [4:3] timer_select
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // [0] selected_timed_out, [4:1] expired_mask,
                                                // [8:5] running_mask
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [APB_AW-1:0]      i_paddr,
    input  logic [APB_DW-1:0]      i_pwdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_ops_seen,
    output int                     o_results_seen,
    output int                     o_expiries
);

    // mirrored bank state
    logic [COUNT_WIDTH-1:0] period_q [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  run_q;
    logic [NUM_TIMERS-1:0]  flag_q;

    t_result due_results [$];
    t_result want;
    t_result got;

    int fail_total;
    int pending_total;
    int ops_total;
    int results_total;
    int expiry_total;

    assign o_fail_count   = fail_total;
    assign o_pending      = pending_total;
    assign o_ops_seen     = ops_total;
    assign o_results_seen = results_total;
    assign o_expiries     = expiry_total;

    // apply one operation to the mirrored timers and return the word it yields
    function automatic t_result apply_timer_op(input logic [OP_WIDTH-1:0]  op,
                                               input logic [SEL_WIDTH-1:0] sel);
        logic [COUNT_WIDTH-1:0] nxt;
        t_result                res;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (run_q[i]) begin
                        nxt = count_q[i] + 1'b1;
                        // a zero period expires on the first tick, as does a wrapped count
                        if (nxt >= period_q[i] || nxt == '0) begin
                            count_q[i] = '0;
                            flag_q[i]  = 1'b1;
                            run_q[i]   = 1'b0;
                            expiry_total++;
                        end else begin
                            count_q[i] = nxt;
                        end
                    end else begin
                        count_q[i] = '0;
                    end
                end
            end
            OP_START: begin
                run_q[sel]   = 1'b1;
                count_q[sel] = '0;
                flag_q[sel]  = 1'b0;
            end
            OP_CANCEL: begin
                run_q[sel]   = 1'b0;
                count_q[sel] = '0;
                flag_q[sel]  = 1'b0;
            end
            OP_CLEAR: begin
                flag_q[sel] = 1'b0;
            end
            default: begin
            end
        endcase
        res.selected_timed_out = flag_q[sel];
        res.expired_mask       = flag_q;
        res.running_mask       = run_q;
        return res;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                period_q[i] = PERIOD_RESET[i];
                count_q[i]  = '0;
            end
            run_q  = '0;
            flag_q = '0;
            due_results.delete();
            fail_total    = 0;
            pending_total = 0;
            ops_total     = 0;
            results_total = 0;
            expiry_total  = 0;
        end else begin
            // a result leaving now belongs to an earlier word, so match it first
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[RES_WIDTH-1:0]);
                results_total++;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, got);
                    fail_total++;
                end else begin
                    want = due_results.pop_front();
                    check_field("selected_timed_out", want.selected_timed_out,
                                got.selected_timed_out);
                    check_field("expired_mask", want.expired_mask, got.expired_mask);
                    check_field("running_mask", want.running_mask, got.running_mask);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due_results.push_back(apply_timer_op(i_s_tdata[OP_WIDTH-1:0],
                                                     i_s_tdata[OP_WIDTH +: SEL_WIDTH]));
                ops_total++;
            end
            if (i_psel && i_penable && i_pwrite && i_pready)
                period_q[i_paddr[APB_AW-1:2]] = i_pwdata[COUNT_WIDTH-1:0];
            pending_total = due_results.size();
        end
    end

endmodule

@@ tb/sv/network_mgmt_alarm_timer_bank_core_tb.sv @@
// Testbench top for the alarm timer bank: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module network_mgmt_alarm_timer_bank_core_tb;
    import nmatb_pkg::*;

    // codes that the bank does not decode; they must behave as a query
    localparam logic [OP_WIDTH-1:0] OP_SPARE_FIRST = OP_QUERY + 1'b1;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_LAST  = '1;

    // cycles without any word moving on either stream or the APB port before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_AW-1:0]      paddr    = '0;
    logic [APB_DW-1:0]      pwdata   = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int fail_count;
    int pending;
    int ops_seen;
    int results_seen;
    int expiries;

    // idling odds, in percent, for the operation sender and the result receiver
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    network_mgmt_alarm_timer_bank_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    alarm_bank_checker scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_ops_seen     (ops_seen),
        .o_results_seen (results_seen),
        .o_expiries     (expiries)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: drop tready at random according to the current idling odds.
    // With the odds at zero this holds tready high for whole stretches.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles in which no word moves on either stream or the APB port.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d result words outstanding", $time, pending);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one operation word, idling first at random, and hold it until accepted.
    // tvalid gets one assignment per step, so a back-to-back word keeps it high.
    task automatic send_word(input logic [OP_WIDTH-1:0] op, input logic [SEL_WIDTH-1:0] sel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({sel, op});
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Stop sending and hold off until every predicted result word has been taken.
    task automatic settle_bank();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write all four periods over APB, lowest register first. The bits above the
    // 12-bit period carry noise; the bank must drop them.
    task automatic program_periods(input logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] periods);
        logic [APB_DW-1:0] word;
        for (int r = 0; r < NUM_TIMERS; r++) begin
            word                  = $urandom();
            word[COUNT_WIDTH-1:0] = periods[r];
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_AW'(r << 2);
            pwdata  <= word;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random operations, weighted towards ticks and starts so that timers run
    // out often. Now and then pause until the bank has answered everything.
    task automatic random_ops(input int count);
        int                   pick;
        logic [OP_WIDTH-1:0]  op;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                op = OP_TICK;
            else if (pick < 63)
                op = OP_START;
            else if (pick < 71)
                op = OP_CANCEL;
            else if (pick < 81)
                op = OP_CLEAR;
            else if (pick < 93)
                op = OP_QUERY;
            else
                op = OP_WIDTH'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            send_word(op, SEL_WIDTH'($urandom_range(NUM_TIMERS - 1)));
            if ($urandom_range(59) == 0)
                settle_bank();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1: sender idles lightly, receiver heavily; start on the reset periods.
        send_idle_pct = 29;
        recv_idle_pct = 67;
        random_ops(60);
        settle_bank();

        // Zero, one, two and three ticks: expiries come quickly.
        program_periods({12'd3, 12'd2, 12'd1, 12'd0});

        // Directed: fresh state of every timer
        for (int t = 0; t < NUM_TIMERS; t++)
            send_word(OP_QUERY, SEL_WIDTH'(t));
        // zero period expires on the very first tick
        send_word(OP_START, REG_TYPICAL_PERIOD);
        send_word(OP_TICK, REG_TYPICAL_PERIOD);
        // one-tick timer expires, the others advance
        send_word(OP_START, REG_MAX_PERIOD);
        send_word(OP_START, REG_ERROR_PERIOD);
        send_word(OP_START, REG_SLEEP_PERIOD);
        send_word(OP_TICK, REG_MAX_PERIOD);
        // restart a running timer: its count goes back to zero
        send_word(OP_START, REG_ERROR_PERIOD);
        send_word(OP_TICK, REG_ERROR_PERIOD);
        // error and sleep timers expire on the same tick
        send_word(OP_TICK, REG_SLEEP_PERIOD);
        send_word(OP_CLEAR, REG_TYPICAL_PERIOD);
        send_word(OP_QUERY, REG_MAX_PERIOD);
        // cancel an expired, stopped timer, then a running one
        send_word(OP_CANCEL, REG_MAX_PERIOD);
        send_word(OP_START, REG_SLEEP_PERIOD);
        send_word(OP_CANCEL, REG_SLEEP_PERIOD);
        // undecoded codes change nothing and report as a query
        send_word(OP_SPARE_FIRST, REG_ERROR_PERIOD);
        send_word(OP_SPARE_FIRST + 1'b1, REG_SLEEP_PERIOD);
        send_word(OP_SPARE_LAST, REG_TYPICAL_PERIOD);
        send_word(OP_CLEAR, REG_ERROR_PERIOD);
        // tick with a select that the bank must ignore
        send_word(OP_TICK, REG_SLEEP_PERIOD);

        random_ops(110);
        settle_bank();

        // Phase 2: idling swapped; full-range period on the typical timer.
        send_idle_pct = 67;
        recv_idle_pct = 29;
        program_periods({12'd12, 12'd7, 12'd1, 12'd4095});
        random_ops(110);
        settle_bank();

        // Phase 3: no idling. Long back-to-back tick runs; the maximum timer sits
        // on the largest period and keeps counting throughout.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_periods({12'd120, 12'd1, 12'd4095, 12'd100});
        send_word(OP_START, REG_TYPICAL_PERIOD);
        send_word(OP_START, REG_MAX_PERIOD);
        send_word(OP_START, REG_SLEEP_PERIOD);
        for (int n = 0; n < 128; n++) begin
            send_word(OP_TICK, SEL_WIDTH'($urandom_range(NUM_TIMERS - 1)));
            if (n % 32 == 0)
                send_word(OP_QUERY, SEL_WIDTH'($urandom_range(NUM_TIMERS - 1)));
        end
        send_word(OP_START, REG_ERROR_PERIOD);
        send_word(OP_TICK, REG_ERROR_PERIOD);
        settle_bank();

        program_periods({12'd5, 12'd9, 12'd3, 12'd2});
        random_ops(60);
        settle_bank();

        // Let any stray result word surface before the verdict.
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d operation words and %0d result words, %0d timer expiries,",
                 ops_seen, results_seen, expiries);
        $display("over reset, zero, one-tick and full-range periods with and without idling.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ network_mgmt_alarm_timer_bank_core.f @@
hdl/nmatb_pkg.sv
hdl/nmatb_timer_bank.sv
hdl/network_mgmt_alarm_timer_bank_core.sv
tb/sv/alarm_bank_checker.sv
tb/sv/network_mgmt_alarm_timer_bank_core_tb.sv
